// ----- rtl/srtr_pkg.sv -----
// ----------------------------------------------------------------------------
// srtr_pkg
// Shared codes, field widths and defaults for the segment reassembly and
// timestamp rebase unit.
// ----------------------------------------------------------------------------
`default_nettype none

package srtr_pkg;

   // field widths
   localparam int CODEC_W  = 2;
   localparam int KIND_W   = 3;
   localparam int FLEN_W   = 24;
   localparam int PART_W   = 16;
   localparam int TICK_W   = 32;
   localparam int STATUS_W = 2;
   localparam int WOFF_W   = 20;
   localparam int WLEN_W   = 21;

   // control and status register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AV_LINKED     = 1'd1;
   localparam logic [TICK_W-1:0]    GAP_THRESHOLD_RST = 32'd1000;

   // codec codes
   localparam logic [CODEC_W-1:0] CODEC_H264  = 2'd0;
   localparam logic [CODEC_W-1:0] CODEC_JPEG  = 2'd1;
   localparam logic [CODEC_W-1:0] CODEC_AUDIO = 2'd2;
   localparam logic [CODEC_W-1:0] CODEC_NONE  = 2'd3;

   // segment kinds
   localparam logic [KIND_W-1:0] KIND_START  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MIDDLE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LAST   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INDEP  = 3'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_ACCEPT   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_ERROR    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_COMPLETE = 2'd2;

   // channels
   localparam int NUM_CH = 2;
   localparam logic CH_VIDEO = 1'b0;
   localparam logic CH_AUDIO = 1'b1;

   // default buffer sizes
   localparam int VIDEO_MAX_BYTES_DEF = 1048576;
   localparam int AUDIO_MAX_BYTES_DEF = 8192;

endpackage

`default_nettype wire

// ----- rtl/srtr_if.sv -----
// ----------------------------------------------------------------------------
// srtr_req_if / srtr_rsp_if
// Valid/ready channels for packet headers and per-packet results.
// ----------------------------------------------------------------------------
`default_nettype none

interface srtr_req_if;
   import srtr_pkg::*;

   logic                valid;
   logic                ready;
   logic [CODEC_W-1:0]  codec;
   logic [KIND_W-1:0]   segment_kind;
   logic [FLEN_W-1:0]   frame_length;
   logic [PART_W-1:0]   part_length;
   logic [TICK_W-1:0]   source_tick;
   logic [TICK_W-1:0]   wall_ms;

   modport source (output valid, codec, segment_kind, frame_length, part_length,
                   source_tick, wall_ms, input ready);
   modport sink   (input valid, codec, segment_kind, frame_length, part_length,
                   source_tick, wall_ms, output ready);
endinterface

interface srtr_rsp_if;
   import srtr_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                dropped;
   logic                write_enable;
   logic [WOFF_W-1:0]   write_offset;
   logic [WLEN_W-1:0]   write_length;
   logic [TICK_W-1:0]   out_timestamp;

   modport source (output valid, status, dropped, write_enable, write_offset,
                   write_length, out_timestamp, input ready);
   modport sink   (input valid, status, dropped, write_enable, write_offset,
                   write_length, out_timestamp, output ready);
endinterface

`default_nettype wire

// ----- rtl/segment_reassembly_timestamp_rebase_unit.sv -----
// ----------------------------------------------------------------------------
// segment_reassembly_timestamp_rebase_unit
// Per-packet reassembly offset tracking and timestamp rebase for a video and
// an audio channel; channel state lives in a small RAM.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake      Carries
//   req_bus   in         valid/ready    one packet header per transfer
//   rsp_bus   out        valid/ready    one result per packet
//   csr_*     in         write enable   gap_threshold, av_linked
//
// A header is accepted when the state stage is free; channel state is read
// from RAM at that edge, and the result is registered in the output register,
// one header per cycle while the output is not stalled. The RAM read-modify-write
// loop sets the rate; a back-to-back packet on the same channel takes the
// previous write from a bypass register. After reset no clearing pass is
// needed; per-entry valid bits make unwritten state read as zero. A stalled
// output register holds the packet in the state stage and stops intake.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_reassembly_timestamp_rebase_unit #(
   parameter int VIDEO_MAX_BYTES = srtr_pkg::VIDEO_MAX_BYTES_DEF,
   parameter int AUDIO_MAX_BYTES = srtr_pkg::AUDIO_MAX_BYTES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   srtr_req_if.sink                               req_bus,
   srtr_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [srtr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [srtr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import srtr_pkg::*;

   localparam int MAXB_ALL = (VIDEO_MAX_BYTES > AUDIO_MAX_BYTES) ?
                             VIDEO_MAX_BYTES : AUDIO_MAX_BYTES;
   localparam int FILL_W   = $clog2(MAXB_ALL + 1);
   localparam int END_W    = ((FILL_W > PART_W) ? FILL_W : PART_W) + 1;
   localparam int CMP_W0   = (END_W > FLEN_W + 1) ? END_W : FLEN_W + 1;
   localparam int CMP_W    = (CMP_W0 > FILL_W) ? CMP_W0 : FILL_W;

   typedef struct packed {
      logic [FILL_W-1:0] fill_offset;
      logic              tick_started;
      logic [TICK_W-1:0] base_tick;
      logic [TICK_W-1:0] base_output;
      logic [TICK_W-1:0] last_tick;
      logic [TICK_W-1:0] last_wall;
      logic [TICK_W-1:0] current_output;
   } chan_state_type;

   localparam int ST_W = $bits(chan_state_type);

   // configuration registers
   logic [TICK_W-1:0] gap_threshold_ff;
   logic              av_linked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_threshold_ff <= GAP_THRESHOLD_RST;
         av_linked_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAP_THRESHOLD: gap_threshold_ff <= csr_wdata[TICK_W-1:0];
            CSR_AV_LINKED:     av_linked_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // handshake and stage control
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_adv;
   logic req_xfer;

   assign s1_adv   = !rsp_valid_ff || rsp_bus.ready;
   assign req_xfer = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !s1_valid_ff || s1_adv;

   // state stage payload
   logic [CODEC_W-1:0] s1_codec_ff;
   logic [KIND_W-1:0]  s1_kind_ff;
   logic [FLEN_W-1:0]  s1_flen_ff;
   logic [PART_W-1:0]  s1_part_ff;
   logic [TICK_W-1:0]  s1_tick_ff;
   logic [TICK_W-1:0]  s1_wall_ff;
   logic               s1_ch;

   assign s1_ch = (s1_codec_ff == CODEC_AUDIO) ? CH_AUDIO : CH_VIDEO;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_codec_ff <= req_bus.codec;
         s1_kind_ff  <= req_bus.segment_kind;
         s1_flen_ff  <= req_bus.frame_length;
         s1_part_ff  <= req_bus.part_length;
         s1_tick_ff  <= req_bus.source_tick;
         s1_wall_ff  <= req_bus.wall_ms;
      end
   end

   // channel state RAM with bypass of the latest write
   logic           req_ch;
   logic           st_we;
   chan_state_type st_rd, st_cur, st_new;
   logic [ST_W-1:0] st_rd_bits;
   logic [NUM_CH-1:0] entry_valid_ff;
   logic           fwd_valid_ff;
   logic           fwd_ch_ff;
   chan_state_type fwd_data_ff;

   assign req_ch = (req_bus.codec == CODEC_AUDIO) ? CH_AUDIO : CH_VIDEO;
   assign st_rd  = chan_state_type'(st_rd_bits);

   srtr_ram #(
      .WIDTH (ST_W),
      .DEPTH (NUM_CH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (s1_ch),
      .wr_data (ST_W'(st_new)),
      .rd_en   (req_xfer),
      .rd_addr (req_ch),
      .rd_data (st_rd_bits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         fwd_valid_ff   <= 1'b0;
      end else if (st_we) begin
         entry_valid_ff[s1_ch] <= 1'b1;
         fwd_valid_ff          <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         fwd_ch_ff   <= s1_ch;
         fwd_data_ff <= st_new;
      end
   end

   // pick bypass, stored entry or reset value
   always_comb begin
      if (fwd_valid_ff && (fwd_ch_ff == s1_ch)) begin
         st_cur = fwd_data_ff;
      end else if (entry_valid_ff[s1_ch]) begin
         st_cur = st_rd;
      end else begin
         st_cur = '0;
      end
   end

   // timestamp update and segment placement
   logic [TICK_W-1:0] bt, bo, lt, step, tick_gap, cur_out;
   logic              rebase, fwd_jump;
   logic [CMP_W-1:0]  end_c, flen_c, maxb_c, part_c, fill_c;
   logic [STATUS_W-1:0] res_status;
   logic                res_dropped, res_wen;
   logic [WOFF_W-1:0]   res_woff;
   logic [WLEN_W-1:0]   res_wlen;
   logic [TICK_W-1:0]   res_ts;
   logic [FILL_W-1:0]   fill_new;

   always_comb begin
      // first packet seeds the base
      if (st_cur.tick_started) begin
         bt = st_cur.base_tick;
         bo = st_cur.base_output;
         lt = st_cur.last_tick;
      end else begin
         bt = s1_tick_ff;
         bo = '0;
         lt = s1_tick_ff;
      end

      fwd_jump = (s1_tick_ff > lt) && ((s1_tick_ff - lt) > gap_threshold_ff) &&
                 !av_linked_ff;
      if (s1_codec_ff == CODEC_JPEG) begin
         rebase = s1_tick_ff < lt;
      end else begin
         rebase = (s1_tick_ff < lt) || fwd_jump;
      end

      step = (st_cur.last_wall > s1_wall_ff) ? (st_cur.last_wall - s1_wall_ff) :
                                               (s1_wall_ff - st_cur.last_wall);
      if (step == '0) begin
         step = TICK_W'(1);
      end
      tick_gap = (s1_tick_ff > bt) ? (s1_tick_ff - bt) : (bt - s1_tick_ff);

      if (rebase) begin
         cur_out = st_cur.current_output + step;
         bt      = s1_tick_ff;
         bo      = cur_out;
      end else begin
         cur_out = tick_gap + bo;
      end

      // segment placement
      fill_c = CMP_W'(st_cur.fill_offset);
      part_c = CMP_W'(s1_part_ff);
      flen_c = CMP_W'(s1_flen_ff);
      maxb_c = (s1_ch == CH_AUDIO) ? CMP_W'(AUDIO_MAX_BYTES) : CMP_W'(VIDEO_MAX_BYTES);
      end_c  = fill_c + part_c;

      res_status  = STAT_ACCEPT;
      res_dropped = 1'b0;
      res_wen     = 1'b0;
      res_woff    = '0;
      res_wlen    = '0;
      fill_new    = st_cur.fill_offset;

      unique case (s1_kind_ff)
         KIND_START: begin
            if (flen_c > maxb_c) begin
               res_status = STAT_ERROR;
            end else if (part_c > flen_c) begin
               fill_new    = '0;
               res_status  = STAT_ERROR;
               res_dropped = 1'b1;
            end else begin
               res_wen  = 1'b1;
               res_wlen = WLEN_W'(s1_part_ff);
               fill_new = FILL_W'(part_c);
            end
         end
         KIND_MIDDLE, KIND_LAST: begin
            if ((end_c > flen_c) || (end_c > maxb_c)) begin
               fill_new    = '0;
               res_dropped = 1'b1;
            end else begin
               res_wen  = 1'b1;
               res_woff = WOFF_W'(st_cur.fill_offset);
               res_wlen = WLEN_W'(s1_part_ff);
               if (s1_kind_ff == KIND_MIDDLE) begin
                  fill_new = FILL_W'(end_c);
               end else begin
                  fill_new   = '0;
                  res_status = STAT_COMPLETE;
               end
            end
         end
         KIND_INDEP: begin
            if (flen_c > maxb_c) begin
               res_status = STAT_ERROR;
            end else begin
               res_wen    = 1'b1;
               res_wlen   = WLEN_W'(s1_flen_ff);
               res_status = STAT_COMPLETE;
            end
         end
         default: ;
      endcase

      res_ts = cur_out;

      // unused codec leaves state alone
      if (s1_codec_ff == CODEC_NONE) begin
         res_status  = STAT_ERROR;
         res_dropped = 1'b0;
         res_wen     = 1'b0;
         res_woff    = '0;
         res_wlen    = '0;
         res_ts      = '0;
      end

      st_new.fill_offset    = fill_new;
      st_new.tick_started   = 1'b1;
      st_new.base_tick      = bt;
      st_new.base_output    = bo;
      st_new.last_tick      = s1_tick_ff;
      st_new.last_wall      = s1_wall_ff;
      st_new.current_output = cur_out;
   end

   assign st_we = s1_valid_ff && s1_adv && (s1_codec_ff != CODEC_NONE);

   // stage valids
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_dropped_ff;
   logic                rsp_wen_ff;
   logic [WOFF_W-1:0]   rsp_woff_ff;
   logic [WLEN_W-1:0]   rsp_wlen_ff;
   logic [TICK_W-1:0]   rsp_ts_ff;

   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         rsp_status_ff  <= res_status;
         rsp_dropped_ff <= res_dropped;
         rsp_wen_ff     <= res_wen;
         rsp_woff_ff    <= res_woff;
         rsp_wlen_ff    <= res_wlen;
         rsp_ts_ff      <= res_ts;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.dropped       = rsp_dropped_ff;
   assign rsp_bus.write_enable  = rsp_wen_ff;
   assign rsp_bus.write_offset  = rsp_woff_ff;
   assign rsp_bus.write_length  = rsp_wlen_ff;
   assign rsp_bus.out_timestamp = rsp_ts_ff;

endmodule

`default_nettype wire

// ----- rtl/srtr_ram.sv -----
// ----------------------------------------------------------------------------
// srtr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port, read-before-write on the read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
